### rtl/core/fqid_pkg.sv
// ----------------------------------------------------------------------------
// fqid_pkg
// Shared types and codes for the unique-id fifo queue: transaction payloads,
// status codes and sequencer states.
// ----------------------------------------------------------------------------
package fqid_pkg;

    localparam int ID_W   = 32;
    localparam int CNT_W  = 32;
    localparam int STAT_W = 3;
    localparam int OCC_W  = 5;

    // operation codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_ENQ   = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STAT_W-1:0] ST_DEQ   = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd4;

    typedef struct packed {
        logic                    cmd;
        logic signed [ID_W-1:0]  entry_id;
        logic signed [CNT_W-1:0] entry_count;
    } fqid_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [ID_W-1:0]  out_id;
        logic signed [CNT_W-1:0] out_count;
        logic [OCC_W-1:0]        occupancy;
        logic                    is_empty;
    } fqid_out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } fqid_state_t;

endpackage

### rtl/core/fifo_queue_unique_id_unit.sv
// ----------------------------------------------------------------------------
// fifo_queue_unique_id_unit
// Bounded fifo queue of (id, count) entries that refuses an enqueue whose id
// is already queued, and refuses it when the ring is full.
// ----------------------------------------------------------------------------
// sequence: an enqueue reads the ring once per queued entry, compares each
//   id as its read data returns, ends the scan and then updates; a dequeue
//   reads the head entry only, and only when the queue is not empty
// flow: one transaction at a time, the next accepted once the result has
//   loaded into the output register; in_stall is high meanwhile
// reset: rst_n clears pointers, fill level and control; ring contents are
//   left as they are and only slots holding queued entries are ever read
// ----------------------------------------------------------------------------
module fifo_queue_unique_id_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fqid_pkg::fqid_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output fqid_pkg::fqid_out_t out_data
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_LVL  = FILL_W'(QUEUE_DEPTH);

    // sequencer
    fqid_pkg::fqid_state_t state_reg, state_next;

    // captured transaction
    logic                                 cmd_reg, cmd_next;
    logic signed [fqid_pkg::ID_W-1:0]     id_reg, id_next;
    logic signed [fqid_pkg::CNT_W-1:0]    cnt_reg, cnt_next;

    // scan control
    logic [PTR_W-1:0]  scan_ptr_reg, scan_ptr_next;
    logic [FILL_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [FILL_W-1:0] scan_lim_reg, scan_lim_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              dup_reg, dup_next;

    // queue state
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    fqid_pkg::fqid_out_t  out_data_reg, out_data_next;

    // ring port
    logic                               rd_en;
    logic                               wr_en;
    logic signed [fqid_pkg::ID_W-1:0]   rd_id;
    logic signed [fqid_pkg::CNT_W-1:0]  rd_count;

    logic accept;
    logic scan_done;
    logic out_free;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        begin
            next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
        end
    endfunction

    fqid_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W)
    ) u_ring (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (tail_reg),
        .wr_id    (id_reg),
        .wr_count (cnt_reg),
        .rd_en    (rd_en),
        .rd_addr  (scan_ptr_reg),
        .rd_id    (rd_id),
        .rd_count (rd_count)
    );

    assign in_stall  = (state_reg != fqid_pkg::S_IDLE);
    assign accept    = in_valid && (state_reg == fqid_pkg::S_IDLE);
    // one ring read per cycle until the scan limit is reached
    assign rd_en     = (state_reg == fqid_pkg::S_SCAN) && (scan_cnt_reg != scan_lim_reg);
    // last read issued and its data already compared
    assign scan_done = (scan_cnt_reg == scan_lim_reg) && !rd_vld_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fqid_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = fqid_pkg::S_SCAN;
                end
            end
            fqid_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = fqid_pkg::S_UPDATE;
                end
            end
            fqid_pkg::S_UPDATE:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    state_next = fqid_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fqid_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        cnt_next       = cnt_reg;
        scan_ptr_next  = scan_ptr_reg;
        scan_cnt_next  = scan_cnt_reg;
        scan_lim_next  = scan_lim_reg;
        rd_vld_next    = rd_en;
        dup_next       = dup_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        wr_en          = 1'b0;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            fqid_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next      = in_data.cmd;
                    id_next       = in_data.entry_id;
                    cnt_next      = in_data.entry_count;
                    scan_ptr_next = head_reg;
                    scan_cnt_next = '0;
                    dup_next      = 1'b0;
                    // enqueue scans every queued id, dequeue reads the head only
                    if (in_data.cmd == fqid_pkg::CMD_ENQ)
                    begin
                        scan_lim_next = fill_reg;
                    end
                    else
                    begin
                        scan_lim_next = (fill_reg != '0) ? FILL_W'(1) : '0;
                    end
                end
            end
            fqid_pkg::S_SCAN:
            begin
                if (rd_en)
                begin
                    scan_ptr_next = next_slot(scan_ptr_reg);
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                // compare runs in the cycle after the read, on the registered read data
                if (rd_vld_reg && (cmd_reg == fqid_pkg::CMD_ENQ) && (rd_id == id_reg))
                begin
                    dup_next = 1'b1;
                end
            end
            fqid_pkg::S_UPDATE:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.out_id    = '0;
                    out_data_next.out_count = '0;
                    if (cmd_reg == fqid_pkg::CMD_ENQ)
                    begin
                        if (dup_reg)
                        begin
                            out_data_next.status = fqid_pkg::ST_DUP;
                        end
                        else if (fill_reg == FULL_LVL)
                        begin
                            out_data_next.status = fqid_pkg::ST_FULL;
                        end
                        else
                        begin
                            out_data_next.status = fqid_pkg::ST_ENQ;
                            wr_en     = 1'b1;
                            tail_next = next_slot(tail_reg);
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (fill_reg == '0)
                        begin
                            out_data_next.status = fqid_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            out_data_next.status    = fqid_pkg::ST_DEQ;
                            out_data_next.out_id    = rd_id;
                            out_data_next.out_count = rd_count;
                            head_next = next_slot(head_reg);
                            fill_next = fill_reg - 1'b1;
                        end
                    end
                    out_data_next.occupancy = fqid_pkg::OCC_W'(fill_next);
                    out_data_next.is_empty  = (fill_next == '0);
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fqid_pkg::S_IDLE;
            scan_ptr_reg  <= '0;
            scan_cnt_reg  <= '0;
            scan_lim_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            dup_reg       <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_ptr_reg  <= scan_ptr_next;
            scan_cnt_reg  <= scan_cnt_next;
            scan_lim_reg  <= scan_lim_next;
            rd_vld_reg    <= rd_vld_next;
            dup_reg       <= dup_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

endmodule

### rtl/core/fqid_ring.sv
// ----------------------------------------------------------------------------
// fqid_ring
// Ring storage for queued entries: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module fqid_ring #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PTR_W       = 4
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [PTR_W-1:0]                 wr_addr,
    input  logic signed [fqid_pkg::ID_W-1:0] wr_id,
    input  logic signed [fqid_pkg::CNT_W-1:0] wr_count,
    input  logic                             rd_en,
    input  logic [PTR_W-1:0]                 rd_addr,
    output logic signed [fqid_pkg::ID_W-1:0] rd_id,
    output logic signed [fqid_pkg::CNT_W-1:0] rd_count
);

    logic signed [fqid_pkg::ID_W-1:0]  id_mem    [QUEUE_DEPTH];
    logic signed [fqid_pkg::CNT_W-1:0] count_mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem[wr_addr]    <= wr_id;
            count_mem[wr_addr] <= wr_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_id    <= id_mem[rd_addr];
            rd_count <= count_mem[rd_addr];
        end
    end

endmodule

### tb/sv/fifo_queue_unique_id_unit_tb.sv
// ----------------------------------------------------------------------------
// fifo_queue_unique_id_unit_tb
// Self-checking bench for the unique-id fifo queue. A shadow copy of the ring
// predicts every result at input acceptance. A checker process compares each
// accepted result field by field with the oldest prediction. Directed tests
// cover the corners, and random traffic at varying enqueue mixes sweeps the
// queue between empty and full under random idling and a long output stall.
// ----------------------------------------------------------------------------
module fifo_queue_unique_id_unit_tb;

    localparam int CLK_PERIOD     = 12;
    localparam int QUEUE_DEPTH    = 16;
    localparam int TIMEOUT_CYCLES = 400000;
    // covers the longest enqueue, a scan of a full ring, plus some margin
    localparam int DRAIN_CYCLES   = 30;

    localparam logic signed [fqid_pkg::ID_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [fqid_pkg::ID_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    fqid_pkg::fqid_in_t  in_data;
    logic                out_valid;
    logic                out_stall;
    fqid_pkg::fqid_out_t out_data;

    // shadow copy of the ring, updated when a transaction is accepted
    logic signed [fqid_pkg::ID_W-1:0]  shadow_ids    [QUEUE_DEPTH];
    logic signed [fqid_pkg::CNT_W-1:0] shadow_counts [QUEUE_DEPTH];
    int shadow_head;
    int shadow_tail;
    int shadow_fill;

    // results predicted but not yet seen at the output, oldest first
    fqid_pkg::fqid_out_t awaited_results[$];
    int                  mismatch_count;

    // idling controls shared between the test tasks and the checker
    bit sender_idles;
    bit receiver_idles;
    int hold_off_cycles;

    fifo_queue_unique_id_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // apply one operation to the shadow ring and return the result it produces
    function automatic fqid_pkg::fqid_out_t shadow_queue_step(input fqid_pkg::fqid_in_t req);
        fqid_pkg::fqid_out_t res;
        bit                  id_queued;
        int                  slot;
        res = '0;
        if (req.cmd == fqid_pkg::CMD_ENQ)
        begin
            // walk only the live entries, so stale slots never match
            id_queued = 1'b0;
            slot = shadow_head;
            for (int k = 0; k < shadow_fill; k++)
            begin
                if (shadow_ids[slot] == req.entry_id)
                    id_queued = 1'b1;
                slot = (slot + 1) % QUEUE_DEPTH;
            end
            // duplicate wins over full
            if (id_queued)
                res.status = fqid_pkg::ST_DUP;
            else if (shadow_fill >= QUEUE_DEPTH)
                res.status = fqid_pkg::ST_FULL;
            else
            begin
                shadow_ids[shadow_tail]    = req.entry_id;
                shadow_counts[shadow_tail] = req.entry_count;
                shadow_tail = (shadow_tail + 1) % QUEUE_DEPTH;
                shadow_fill++;
                res.status = fqid_pkg::ST_ENQ;
            end
        end
        else
        begin
            if (shadow_fill == 0)
                res.status = fqid_pkg::ST_EMPTY;
            else
            begin
                res.out_id    = shadow_ids[shadow_head];
                res.out_count = shadow_counts[shadow_head];
                shadow_head = (shadow_head + 1) % QUEUE_DEPTH;
                shadow_fill--;
                res.status = fqid_pkg::ST_DEQ;
            end
        end
        res.occupancy = fqid_pkg::OCC_W'(shadow_fill);
        res.is_empty  = (shadow_fill == 0);
        return res;
    endfunction

    // ids cluster in a small pool so duplicates are common, with extremes and
    // full-range values mixed in
    function automatic logic signed [fqid_pkg::ID_W-1:0] draw_entry_id();
        int pick;
        pick = $urandom_range(0, 11);
        if (pick < 7)
            return $urandom_range(0, 23) - 4;
        else if (pick == 7)
            return VAL_MAX;
        else if (pick == 8)
            return VAL_MIN;
        else
            return $urandom;
    endfunction

    function automatic logic signed [fqid_pkg::CNT_W-1:0] draw_entry_count();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return VAL_MAX;
        else if (pick == 1)
            return VAL_MIN;
        else
            return $urandom;
    endfunction

    function automatic fqid_pkg::fqid_in_t make_request(
        input logic                              cmd,
        input logic signed [fqid_pkg::ID_W-1:0]  id,
        input logic signed [fqid_pkg::CNT_W-1:0] cnt);
        fqid_pkg::fqid_in_t req;
        req.cmd         = cmd;
        req.entry_id    = id;
        req.entry_count = cnt;
        return req;
    endfunction

    // offer one transaction after a random gap, hold it until accepted, then
    // record the predicted result; entered and left at a rising edge
    task automatic send_request(input fqid_pkg::fqid_in_t req);
        int gap;
        gap = sender_idles ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        awaited_results.push_back(shadow_queue_step(req));
    endtask

    // compare one accepted result with the oldest prediction
    task automatic check_result(input fqid_pkg::fqid_out_t got);
        fqid_pkg::fqid_out_t want;
        if (awaited_results.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual %h", $time, got);
            mismatch_count++;
        end
        else
        begin
            want = awaited_results.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status: expected %0d, actual %0d",
                         $time, want.status, got.status);
                mismatch_count++;
            end
            if (got.out_id !== want.out_id)
            begin
                $display("%0t: out_id: expected %0d, actual %0d",
                         $time, want.out_id, got.out_id);
                mismatch_count++;
            end
            if (got.out_count !== want.out_count)
            begin
                $display("%0t: out_count: expected %0d, actual %0d",
                         $time, want.out_count, got.out_count);
                mismatch_count++;
            end
            if (got.occupancy !== want.occupancy)
            begin
                $display("%0t: occupancy: expected %0d, actual %0d",
                         $time, want.occupancy, got.occupancy);
                mismatch_count++;
            end
            if (got.is_empty !== want.is_empty)
            begin
                $display("%0t: is_empty: expected %0d, actual %0d",
                         $time, want.is_empty, got.is_empty);
                mismatch_count++;
            end
        end
    endtask

    // output side: stall for a random count (or a requested long hold-off),
    // then take the next result and check it
    initial
    begin
        int wait_cycles;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
                wait_cycles = hold_off_cycles;
            else
                wait_cycles = receiver_idles ? $urandom_range(0, 3) : 0;
            hold_off_cycles = 0;
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            check_result(out_data);
        end
    end

    // empty dequeue, then enqueue into an empty queue whose ring still holds
    // the same id in a stale slot: must be accepted
    task automatic test_empty_queue;
        send_request(make_request(fqid_pkg::CMD_DEQ, VAL_MAX, VAL_MIN));
        send_request(make_request(fqid_pkg::CMD_ENQ, 7, 70));
        send_request(make_request(fqid_pkg::CMD_DEQ, 0, 0));
        send_request(make_request(fqid_pkg::CMD_ENQ, 7, 71));
        send_request(make_request(fqid_pkg::CMD_DEQ, -1, -1));
    endtask

    // fill the ring (wrapping past the end) with extreme ids and counts, then
    // a fresh id is refused as full and a queued id is refused as duplicate
    task automatic test_fill_to_full;
        logic signed [fqid_pkg::ID_W-1:0]  id;
        logic signed [fqid_pkg::CNT_W-1:0] cnt;
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            case (k)
                0:
                begin
                    id  = VAL_MIN;
                    cnt = VAL_MAX;
                end
                1:
                begin
                    id  = VAL_MAX;
                    cnt = VAL_MIN;
                end
                2:
                begin
                    id  = 0;
                    cnt = 0;
                end
                3:
                begin
                    id  = -1;
                    cnt = -1;
                end
                default:
                begin
                    id  = 1000 + k;
                    cnt = $urandom;
                end
            endcase
            send_request(make_request(fqid_pkg::CMD_ENQ, id, cnt));
        end
        send_request(make_request(fqid_pkg::CMD_ENQ, 5000, 1));
        send_request(make_request(fqid_pkg::CMD_ENQ, -1, 2));
    endtask

    // duplicate refusal below full, and re-entry of an id once it has left
    task automatic test_duplicate_refusal;
        send_request(make_request(fqid_pkg::CMD_DEQ, 0, 0));
        send_request(make_request(fqid_pkg::CMD_ENQ, 0, 3));
        send_request(make_request(fqid_pkg::CMD_ENQ, VAL_MIN, 4));
    endtask

    // random mix; the enqueue share steers the queue toward full or empty
    task automatic test_random_traffic(input int n_items, input int enq_percent);
        fqid_pkg::fqid_in_t req;
        for (int i = 0; i < n_items; i++)
        begin
            req.cmd = ($urandom_range(0, 99) < enq_percent) ? fqid_pkg::CMD_ENQ
                                                             : fqid_pkg::CMD_DEQ;
            req.entry_id    = draw_entry_id();
            req.entry_count = draw_entry_count();
            send_request(req);
        end
    endtask

    // back-to-back traffic with neither side idling
    task automatic test_no_idle_stretch;
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        test_random_traffic(300, 55);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // output held off for a long stretch while input keeps coming, so the
    // block backs up and stalls its input
    task automatic test_output_back_pressure;
        sender_idles    = 1'b0;
        hold_off_cycles = 150;
        test_random_traffic(40, 60);
        sender_idles    = 1'b1;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_data         = '0;
        mismatch_count  = 0;
        sender_idles    = 1'b1;
        receiver_idles  = 1'b1;
        hold_off_cycles = 0;
        shadow_head     = 0;
        shadow_tail     = 0;
        shadow_fill     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue;
        test_fill_to_full;
        test_duplicate_refusal;
        test_random_traffic(260, 30);
        test_random_traffic(260, 85);
        test_output_back_pressure;
        test_random_traffic(260, 55);
        test_random_traffic(260, 15);
        test_no_idle_stretch;
        test_random_traffic(260, 70);

        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        // let any stray result show up before closing
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Regression FAIL");
        $finish;
    end

endmodule
